[design/ip6fmt_pkg.sv]
// shared types, codes and character helpers for the ipv6 address text formatter
package ip6fmt_pkg;

   localparam int unsigned ADDR_W  = 128;
   localparam int unsigned GROUP_W = 16;
   localparam int unsigned NGROUPS = 8;
   localparam int unsigned GIDX_W  = 3;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned STYLE_W = 3;

   // style codes
   localparam logic [STYLE_W-1:0] STYLE_CANON  = 3'd0;
   localparam logic [STYLE_W-1:0] STYLE_STRICT = 3'd1;
   localparam logic [STYLE_W-1:0] STYLE_EXPAND = 3'd2;
   localparam logic [STYLE_W-1:0] STYLE_HYPHEN = 3'd3;
   localparam logic [STYLE_W-1:0] STYLE_DOTTED = 3'd4;

   // last group index of the hex part
   localparam logic [GIDX_W-1:0] LAST_GRP_FULL   = 3'd7;
   localparam logic [GIDX_W-1:0] LAST_GRP_DOTTED = 3'd5;

   // ascii codes
   localparam logic [CHAR_W-1:0] CH_COLON  = 7'h3a;
   localparam logic [CHAR_W-1:0] CH_HYPHEN = 7'h2d;
   localparam logic [CHAR_W-1:0] CH_DOT    = 7'h2e;
   localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;
   localparam logic [CHAR_W-1:0] CH_HEX_A  = 7'h57;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_GRP,
      ST_RUN,
      ST_HEX,
      ST_COLON,
      ST_DDIG,
      ST_DSEP
   } ip6fmt_state_type;

   typedef struct packed {
      logic                start;
      logic [ADDR_W-1:0]   addr;
      logic                dotted;
      logic                compress;
      logic [CHAR_W-1:0]   delim;
   } ip6fmt_job_type;

   typedef struct packed {
      logic              start;
      logic [GIDX_W-1:0] last_grp;
   } ip6fmt_scan_ctl_type;

   typedef struct packed {
      logic              done;
      logic              run;
      logic [GIDX_W-1:0] first;
      logic [GIDX_W:0]   stop;
   } ip6fmt_scan_res_type;

   typedef struct packed {
      logic              valid;
      logic [CHAR_W-1:0] code;
      logic              last;
   } ip6fmt_char_type;

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + CHAR_W'(nib);
      end else begin
         c = CH_HEX_A + CHAR_W'(nib);
      end
      return c;
   endfunction

   // index of the top nonzero nibble, zero for a zero group
   function automatic logic [1:0] lead_nib(input logic [GROUP_W-1:0] v);
      logic [1:0] n;
      if (v[15:12] != 4'd0) begin
         n = 2'd3;
      end else if (v[11:8] != 4'd0) begin
         n = 2'd2;
      end else if (v[7:4] != 4'd0) begin
         n = 2'd1;
      end else begin
         n = 2'd0;
      end
      return n;
   endfunction

   // {hundreds, tens, ones} of a byte
   function automatic logic [9:0] dec_digits(input logic [7:0] v);
      logic [1:0]  h;
      logic [6:0]  r;
      logic [14:0] pt;
      logic [3:0]  t;
      logic [3:0]  o;
      if (v >= 8'd200) begin
         h = 2'd2;
         r = 7'(v - 8'd200);
      end else if (v >= 8'd100) begin
         h = 2'd1;
         r = 7'(v - 8'd100);
      end else begin
         h = 2'd0;
         r = 7'(v);
      end
      // r / 10 by reciprocal, exact for r below 100
      pt = 15'(r) * 15'd205;
      t  = 4'(pt >> 11);
      o  = 4'(r - 7'(7'(t) * 7'd10));
      return {h, t, o};
   endfunction

endpackage

[design/ip6fmt_scan.sv]
// zero-run search: walks the groups one per cycle and keeps the first longest run
module ip6fmt_scan (
   input  logic                              clock,
   input  logic                              reset,
   input  ip6fmt_pkg::ip6fmt_scan_ctl_type   ctl,
   input  logic [ip6fmt_pkg::ADDR_W-1:0]     addr,
   output ip6fmt_pkg::ip6fmt_scan_res_type   res
);
   import ip6fmt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [GIDX_W-1:0] g_ff, g_in;
   logic [GIDX_W-1:0] last_ff, last_in;
   logic [GIDX_W-1:0] cur_start_ff, cur_start_in;
   logic [GIDX_W:0]   cur_len_ff, cur_len_in;
   logic [GIDX_W-1:0] best_start_ff, best_start_in;
   logic [GIDX_W:0]   best_len_ff, best_len_in;

   logic [GROUP_W-1:0] grp_w;
   logic [GIDX_W-1:0]  run_start_w;
   logic [GIDX_W:0]    run_len_w;

   assign grp_w       = addr[{~g_ff, 4'b0000} +: GROUP_W];
   assign run_start_w = (cur_len_ff == '0) ? g_ff : cur_start_ff;
   assign run_len_w   = cur_len_ff + 1'b1;

   always_comb begin
      busy_in       = busy_ff;
      done_in       = 1'b0;
      g_in          = g_ff;
      last_in       = last_ff;
      cur_start_in  = cur_start_ff;
      cur_len_in    = cur_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      if (ctl.start) begin
         busy_in       = 1'b1;
         g_in          = '0;
         last_in       = ctl.last_grp;
         cur_start_in  = '0;
         cur_len_in    = '0;
         best_start_in = '0;
         best_len_in   = '0;
      end else if (busy_ff) begin
         if (grp_w == '0) begin
            cur_start_in = run_start_w;
            cur_len_in   = run_len_w;
            if (run_len_w > best_len_ff) begin
               best_len_in   = run_len_w;
               best_start_in = run_start_w;
            end
         end else begin
            cur_len_in = '0;
         end
         if (g_ff == last_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            g_in = g_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         done_ff       <= 1'b0;
         g_ff          <= '0;
         last_ff       <= '0;
         cur_start_ff  <= '0;
         cur_len_ff    <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
      end else begin
         busy_ff       <= busy_in;
         done_ff       <= done_in;
         g_ff          <= g_in;
         last_ff       <= last_in;
         cur_start_ff  <= cur_start_in;
         cur_len_ff    <= cur_len_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
      end
   end

   assign res.done  = done_ff;
   assign res.run   = (best_len_ff >= 4'd2);
   assign res.first = best_start_ff;
   assign res.stop  = {1'b0, best_start_ff} + best_len_ff;

   a_best_covers_cur: assert property (@(posedge clock) disable iff (reset)
      best_len_ff >= cur_len_ff)
      else $error("current zero run longer than best run");

   a_done_after_walk: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("scan done without a finished walk");

   a_run_in_range: assert property (@(posedge clock) disable iff (reset)
      res.run |-> res.stop <= {1'b0, last_ff} + 4'd1)
      else $error("zero run ends past the last group");

endmodule

[design/ip6fmt_emit.sv]
// sequencer: delimiters, hex groups, decimal bytes; one per cycle while slot_free
module ip6fmt_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  ip6fmt_pkg::ip6fmt_job_type        job,
   input  logic                              slot_free,
   input  ip6fmt_pkg::ip6fmt_scan_res_type   scan_res,
   output ip6fmt_pkg::ip6fmt_scan_ctl_type   scan_ctl,
   output logic [ip6fmt_pkg::ADDR_W-1:0]     held_addr,
   output logic                              busy,
   output ip6fmt_pkg::ip6fmt_char_type       chr
);
   import ip6fmt_pkg::*;

   ip6fmt_state_type  state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              dotted_ff, dotted_in;
   logic              compress_ff, compress_in;
   logic [CHAR_W-1:0] delim_ff, delim_in;
   logic [GIDX_W-1:0] g_ff, g_in;
   logic [1:0]        nib_ff, nib_in;
   logic [1:0]        b_ff, b_in;
   logic [1:0]        ph_ff, ph_in;

   logic [GIDX_W-1:0]  last_grp_w;
   logic [GROUP_W-1:0] grp_w;
   logic [7:0]         byte_w;
   logic [9:0]         digits_w;
   logic [3:0]         digit_w;
   logic               run_w;
   logic               at_run_w;
   logic               run_to_end_w;
   logic               skip_w;
   logic               emit_w;
   logic               adv_w;
   logic [CHAR_W-1:0]  code_w;
   logic               last_w;

   assign last_grp_w   = dotted_ff ? LAST_GRP_DOTTED : LAST_GRP_FULL;
   assign grp_w        = addr_ff[{~g_ff, 4'b0000} +: GROUP_W];
   assign byte_w       = addr_ff[{~b_ff, 3'b000} +: 8];
   assign digits_w     = dec_digits(byte_w);
   assign run_w        = scan_res.run & compress_ff;
   assign at_run_w     = run_w && (g_ff == scan_res.first);
   assign run_to_end_w = scan_res.stop > {1'b0, last_grp_w};
   // leading zero digits of a decimal byte are stepped over
   assign skip_w       = ((ph_ff == 2'd2) && (byte_w < 8'd100))
                       || ((ph_ff == 2'd1) && (byte_w < 8'd10));

   always_comb begin
      case (ph_ff)
         2'd2:    digit_w = {2'b00, digits_w[9:8]};
         2'd1:    digit_w = digits_w[7:4];
         default: digit_w = digits_w[3:0];
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_res.done) state_in = ST_GRP;
         end
         ST_GRP: begin
            if (adv_w) state_in = at_run_w ? ST_RUN : ST_HEX;
         end
         ST_RUN: begin
            if (adv_w) begin
               if (run_to_end_w) begin
                  state_in = dotted_ff ? ST_DDIG : ST_IDLE;
               end else begin
                  state_in = ST_GRP;
               end
            end
         end
         ST_HEX: begin
            if (adv_w && (nib_ff == 2'd0)) begin
               if (g_ff == last_grp_w) begin
                  state_in = dotted_ff ? ST_COLON : ST_IDLE;
               end else begin
                  state_in = ST_GRP;
               end
            end
         end
         ST_COLON: begin
            if (adv_w) state_in = ST_DDIG;
         end
         ST_DDIG: begin
            if (adv_w && (ph_ff == 2'd0)) begin
               state_in = (b_ff == 2'd3) ? ST_IDLE : ST_DSEP;
            end
         end
         ST_DSEP: begin
            if (adv_w) state_in = ST_DDIG;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      emit_w      = 1'b0;
      code_w      = delim_ff;
      last_w      = 1'b0;
      addr_in     = addr_ff;
      dotted_in   = dotted_ff;
      compress_in = compress_ff;
      delim_in    = delim_ff;
      g_in        = g_ff;
      nib_in      = nib_ff;
      b_in        = b_ff;
      ph_in       = ph_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job.start) begin
               addr_in     = job.addr;
               dotted_in   = job.dotted;
               compress_in = job.compress;
               delim_in    = job.delim;
            end
         end
         ST_SCAN: begin
            g_in = '0;
         end
         ST_GRP: begin
            if (at_run_w) begin
               emit_w = 1'b1;
            end else begin
               emit_w = (g_ff != '0);
               nib_in = lead_nib(grp_w);
            end
         end
         ST_RUN: begin
            if (run_to_end_w) begin
               emit_w = 1'b1;
               last_w = !dotted_ff;
               b_in   = 2'd0;
               ph_in  = 2'd2;
            end else begin
               g_in = scan_res.stop[GIDX_W-1:0];
            end
         end
         ST_HEX: begin
            emit_w = 1'b1;
            code_w = hex_char(grp_w[{nib_ff, 2'b00} +: 4]);
            if (nib_ff == 2'd0) begin
               if (g_ff == last_grp_w) begin
                  last_w = !dotted_ff;
                  b_in   = 2'd0;
               end else if (slot_free) begin
                  g_in = g_ff + 1'b1;
               end
            end else if (slot_free) begin
               nib_in = nib_ff - 1'b1;
            end
         end
         ST_COLON: begin
            emit_w = 1'b1;
            code_w = CH_COLON;
            ph_in  = 2'd2;
         end
         ST_DDIG: begin
            emit_w = !skip_w;
            code_w = CH_ZERO + CHAR_W'(digit_w);
            if (ph_ff == 2'd0) begin
               last_w = (b_ff == 2'd3);
               if (slot_free && (b_ff != 2'd3)) b_in = b_ff + 1'b1;
            end else if (skip_w || slot_free) begin
               ph_in = ph_ff - 1'b1;
            end
         end
         ST_DSEP: begin
            emit_w = 1'b1;
            code_w = CH_DOT;
            ph_in  = 2'd2;
         end
         default: begin
            emit_w = 1'b0;
         end
      endcase
   end

   assign adv_w = !emit_w || slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      dotted_ff   <= dotted_in;
      compress_ff <= compress_in;
      delim_ff    <= delim_in;
      g_ff        <= g_in;
      nib_ff      <= nib_in;
      b_ff        <= b_in;
      ph_ff       <= ph_in;
   end

   assign scan_ctl.start    = (state_ff == ST_IDLE) && job.start;
   assign scan_ctl.last_grp = job.dotted ? LAST_GRP_DOTTED : LAST_GRP_FULL;
   // the scan walks the captured address, the input bus may move on after accept
   assign held_addr         = addr_ff;
   assign busy              = (state_ff != ST_IDLE);
   assign chr.valid         = emit_w && slot_free;
   assign chr.code          = code_w;
   assign chr.last          = last_w;

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chr.valid)
      else $error("character emitted while idle");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      chr.valid && chr.last |=> state_ff == ST_IDLE)
      else $error("sequencer still busy after the final character");

   a_scan_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_res.done |-> state_ff == ST_SCAN)
      else $error("zero-run result arrived outside the scan phase");

endmodule

[design/ipv6_address_text_formatter.sv]
// ipv6 address text formatter top level: one address in, its text out at most a character
// per cycle while the output is not stalled, after a zero-run scan of the groups (0 to 5
// only in dotted-quad form); group 0 is a silent step unless a run starts there, and so
// are stepping over an inner zero run and each leading zero digit of a decimal byte; an
// unused style is accepted with no text; req_tready is high only while the sequencer is
// idle; reset clears the sequencer state, the scan registers and the output valid flag
module ipv6_address_text_formatter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // addr_high [63:0], addr_low [127:64], style [130:128]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // char_code [6:0]
   output logic         rsp_tlast
);
   import ip6fmt_pkg::*;

   logic [63:0]        addr_high_w;
   logic [63:0]        addr_low_w;
   logic [STYLE_W-1:0] style_w;
   logic               v4_w;
   logic               busy_w;
   logic               slot_free_w;
   logic [ADDR_W-1:0]  held_addr_w;

   ip6fmt_job_type      job_w;
   ip6fmt_scan_ctl_type scan_ctl_w;
   ip6fmt_scan_res_type scan_res_w;
   ip6fmt_char_type     chr_w;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0] rsp_code_ff, rsp_code_in;
   logic              rsp_last_ff, rsp_last_in;

   assign addr_high_w = req_tdata[63:0];
   assign addr_low_w  = req_tdata[127:64];
   assign style_w     = req_tdata[130:128];

   // mapped or translated ipv4 prefix
   assign v4_w = (addr_high_w == '0)
              && ((addr_low_w[63:32] == 32'h0000ffff) || (addr_low_w[63:32] == 32'hffff0000));

   assign req_tready = !busy_w;

   always_comb begin
      job_w.start    = 1'b0;
      job_w.addr     = {addr_high_w, addr_low_w};
      job_w.dotted   = 1'b0;
      job_w.compress = 1'b1;
      job_w.delim    = CH_COLON;
      unique case (style_w)
         STYLE_CANON: begin
            job_w.start  = req_tvalid;
            job_w.dotted = v4_w;
         end
         STYLE_STRICT: begin
            job_w.start = req_tvalid;
         end
         STYLE_EXPAND: begin
            job_w.start    = req_tvalid;
            job_w.compress = 1'b0;
         end
         STYLE_HYPHEN: begin
            job_w.start = req_tvalid;
            job_w.delim = CH_HYPHEN;
         end
         STYLE_DOTTED: begin
            job_w.start  = req_tvalid;
            job_w.dotted = 1'b1;
         end
         // unused codes produce no text
         default: begin
            job_w.start = 1'b0;
         end
      endcase
   end

   assign slot_free_w = !rsp_valid_ff || rsp_tready;

   ip6fmt_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl_w),
      .addr  (held_addr_w),
      .res   (scan_res_w)
   );

   ip6fmt_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job       (job_w),
      .slot_free (slot_free_w),
      .scan_res  (scan_res_w),
      .scan_ctl  (scan_ctl_w),
      .held_addr (held_addr_w),
      .busy      (busy_w),
      .chr       (chr_w)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_last_in  = rsp_last_ff;
      if (chr_w.valid) begin
         rsp_valid_in = 1'b1;
         rsp_code_in  = chr_w.code;
         rsp_last_in  = chr_w.last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_code_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule
